// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks with the clock and reset passed in; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME_CYCLE(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_SAME_CYCLE(lbl, clk, rst, a, b)
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, a, b)
`endif
`endif

// ----- rtl/core/mapt_pkg.sv -----
// ----------------------------------------------------------------------------
// mapt_pkg
// Widths, item types, sequencer states and helpers of the triangulation block.
// ----------------------------------------------------------------------------
package mapt_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int COORD_W          = 16;
  localparam int AREA_FRAC_BITS   = 4;
  localparam int CORNER_W         = 5;
  localparam int AREA_W           = 48;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int CROSS_W = 2 * DIFF_W;
  localparam int HALF_W  = CROSS_W / 2;
  localparam int MUL_W   = HALF_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_W    = 2 * CROSS_W + 2;
  localparam int RAD_W   = SQ_W + 2 * AREA_FRAC_BITS;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int SEQ_W   = $clog2(ROOT_W + 1);
  localparam int SH_W    = $clog2(2 * HALF_W + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_vertex;
  } vtx_item_t;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic [AREA_W-1:0]   total_area;
    logic                last_triangle;
  } tri_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic    start;
    vertex_t p;
    vertex_t q;
    vertex_t r;
  } area_req_t;

  typedef struct packed {
    logic              done;
    logic [AREA_W-1:0] area;
  } area_rsp_t;

  typedef enum logic [2:0] {
    AU_IDLE,
    AU_CROSS,
    AU_SQ,
    AU_PREP,
    AU_ROOT,
    AU_DONE
  } au_state_t;

  typedef enum logic [3:0] {
    E_LOAD,
    E_RDV0,
    E_RDV1,
    E_RDV2,
    E_RDV3,
    E_AREA,
    E_ADD2,
    E_WRITE,
    E_SPL,
    E_SPLW,
    E_PUSHR,
    E_PUSHL,
    E_POP,
    E_POPW
  } eng_state_t;

  function automatic logic [AREA_W-1:0] sat_add(input logic [AREA_W-1:0] a,
                                                input logic [AREA_W-1:0] b);
    logic [AREA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AREA_W] ? {AREA_W{1'b1}} : s[AREA_W-1:0];
  endfunction

endpackage

// ----- rtl/core/mapt_stream_if.sv -----
// ----------------------------------------------------------------------------
// mapt_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface mapt_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/mapt_area_unit.sv -----
// ----------------------------------------------------------------------------
// mapt_area_unit
// Triangle area from a shared 18x18 multiplier: cross product, squared norm in
// half-word partial products, then a one-bit-per-cycle square root.
// ----------------------------------------------------------------------------
module mapt_area_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  mapt_pkg::area_req_t  req,
  output mapt_pkg::area_rsp_t  rsp
);
  import mapt_pkg::*;

  localparam int CROSS_STEPS = 6;
  localparam int SQ_STEPS    = 9;

  au_state_t state, state_next;

  logic [SEQ_W-1:0]         cnt;
  logic signed [DIFF_W-1:0] ax, ay, az, bx, by, bz;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, prod_q, first_q;
  logic signed [PROD_W:0]   cdiff;
  logic [CROSS_W-1:0]       cr [3];
  logic [CROSS_W-1:0]       csel;
  logic [1:0]               comp, term;
  logic [SH_W-1:0]          sh, sh_q;
  logic [SQ_W-1:0]          acc;
  logic [RAD_W-1:0]         rad;
  logic [REM_W-1:0]         rem, rem_sh, trial;
  logic [ROOT_W-1:0]        root;
  logic [2:0]               pidx;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sh    = '0;
    case (comp)
      2'd0:    csel = cr[0];
      2'd1:    csel = cr[1];
      2'd2:    csel = cr[2];
      default: csel = '0;
    endcase
    state_next = state;
    case (state)
      AU_IDLE: begin
        if (req.start) state_next = AU_CROSS;
      end
      AU_CROSS: begin
        case (cnt)
          SEQ_W'(0): begin mul_a = MUL_W'(ay); mul_b = MUL_W'(bz); end
          SEQ_W'(1): begin mul_a = MUL_W'(az); mul_b = MUL_W'(by); end
          SEQ_W'(2): begin mul_a = MUL_W'(az); mul_b = MUL_W'(bx); end
          SEQ_W'(3): begin mul_a = MUL_W'(ax); mul_b = MUL_W'(bz); end
          SEQ_W'(4): begin mul_a = MUL_W'(ax); mul_b = MUL_W'(by); end
          SEQ_W'(5): begin mul_a = MUL_W'(ay); mul_b = MUL_W'(bx); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt == SEQ_W'(CROSS_STEPS)) state_next = AU_SQ;
      end
      AU_SQ: begin
        case (term)
          2'd0: begin
            mul_a = $signed({1'b0, csel[HALF_W-1:0]});
            mul_b = $signed({1'b0, csel[HALF_W-1:0]});
            sh    = '0;
          end
          2'd1: begin
            mul_a = $signed({1'b0, csel[CROSS_W-1:HALF_W]});
            mul_b = $signed({1'b0, csel[HALF_W-1:0]});
            sh    = SH_W'(HALF_W + 1);
          end
          2'd2: begin
            mul_a = $signed({1'b0, csel[CROSS_W-1:HALF_W]});
            mul_b = $signed({1'b0, csel[CROSS_W-1:HALF_W]});
            sh    = SH_W'(2 * HALF_W);
          end
          default: begin mul_a = '0; mul_b = '0; sh = '0; end
        endcase
        if (cnt == SEQ_W'(SQ_STEPS)) state_next = AU_PREP;
      end
      AU_PREP: state_next = AU_ROOT;
      AU_ROOT: begin
        if (cnt == SEQ_W'(ROOT_W - 1)) state_next = AU_DONE;
      end
      AU_DONE: state_next = AU_IDLE;
      default: state_next = AU_IDLE;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign cdiff  = {first_q[PROD_W-1], first_q} - {prod_q[PROD_W-1], prod_q};
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign pidx   = cnt[2:0] - 3'd1;

  assign rsp.done = (state == AU_DONE);
  assign rsp.area = AREA_W'(root >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= prod;
    sh_q   <= sh;
    case (state)
      AU_IDLE: begin
        if (req.start) begin
          ax  <= DIFF_W'(req.q.x) - DIFF_W'(req.p.x);
          ay  <= DIFF_W'(req.q.y) - DIFF_W'(req.p.y);
          az  <= DIFF_W'(req.q.z) - DIFF_W'(req.p.z);
          bx  <= DIFF_W'(req.r.x) - DIFF_W'(req.p.x);
          by  <= DIFF_W'(req.r.y) - DIFF_W'(req.p.y);
          bz  <= DIFF_W'(req.r.z) - DIFF_W'(req.p.z);
          cnt <= '0;
        end
      end
      AU_CROSS: begin
        if (cnt != '0) begin
          if (!pidx[0]) begin
            first_q <= prod_q;
          end else begin
            cr[pidx[2:1]] <= CROSS_W'(cdiff[PROD_W] ? -cdiff : cdiff);
          end
        end
        if (cnt == SEQ_W'(CROSS_STEPS)) begin
          cnt  <= '0;
          comp <= '0;
          term <= '0;
          acc  <= '0;
        end else begin
          cnt <= cnt + SEQ_W'(1);
        end
      end
      AU_SQ: begin
        cnt <= cnt + SEQ_W'(1);
        if (cnt != '0) acc <= acc + (SQ_W'($unsigned(prod_q)) << sh_q);
        if (term == 2'd2) begin
          term <= '0;
          comp <= comp + 2'd1;
        end else begin
          term <= term + 2'd1;
        end
      end
      AU_PREP: begin
        rad  <= RAD_W'(acc) << (2 * AREA_FRAC_BITS);
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      AU_ROOT: begin
        cnt <= cnt + SEQ_W'(1);
        rad <= rad << 2;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/mapt_engine.sv -----
// ----------------------------------------------------------------------------
// mapt_engine
// Vertex loading, interval table sequencer over cyclic spans, and depth-first
// triangle emission through an explicit stack.
// ----------------------------------------------------------------------------
module mapt_engine #(
  parameter int MAX_VERTICES = mapt_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  mapt_stream_if.sink         vtx_in,
  mapt_stream_if.source       tri_out,
  output mapt_pkg::area_req_t areq,
  input  mapt_pkg::area_rsp_t arsp
);
  import mapt_pkg::*;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int W1     = IDX_W + 1;
  localparam int TAB_D  = 2 ** (2 * IDX_W);
  localparam int STK_D  = MAX_VERTICES + 2;
  localparam int STK_AW = $clog2(STK_D);
  localparam int SP_W   = $clog2(STK_D + 1);
  localparam int ENT_W  = 2 * IDX_W;

  function automatic logic [W1-1:0] modn(input logic [W1-1:0] x, input logic [W1-1:0] m);
    return (x >= m) ? x - m : x;
  endfunction

  function automatic logic [CORNER_W-1:0] to_corner(input logic [W1-1:0] v);
    logic [W1+CORNER_W-1:0] w;
    w = {{CORNER_W{1'b0}}, v};
    return w[CORNER_W-1:0];
  endfunction

  eng_state_t state, state_next;

  vertex_t           vstore    [MAX_VERTICES];
  logic [AREA_W-1:0] best_mem  [TAB_D];
  logic [IDX_W-1:0]  split_mem [TAB_D];
  logic [ENT_W-1:0]  stack_mem [STK_D];

  logic [W1-1:0]     count, n, n_load, mi, k, mim, km, d1, d2;
  logic [IDX_W-1:0]  j, span, pick, cur_i, cur_span, s_r, spl_q, vaddr;
  logic              first, in_fire, vwr, bwr, brd, b1_zero, b2_zero;
  logic [AREA_W-1:0] best_r, sum1, total_r, b1_q, b2_q, b1v, b2v, cand;
  vertex_t           vq, p_r, q_r, vin;
  logic [W1-1:0]     end_m, ls, rs, ls_r, rs_r, si, ci;
  logic              last_tri, out_load, out_valid, stk_wr, stk_rd;
  logic [SP_W-1:0]   sp;
  logic [ENT_W-1:0]  stk_q, stk_wdata;
  logic [STK_AW-1:0] sp_m1;
  tri_item_t         out_item;

  assign in_fire  = vtx_in.valid && vtx_in.ready;
  assign n_load   = (count < W1'(MAX_VERTICES)) ? count + W1'(1) : count;
  assign vwr      = in_fire && (count < W1'(MAX_VERTICES));
  assign vin.x    = vtx_in.payload.coord_x;
  assign vin.y    = vtx_in.payload.coord_y;
  assign vin.z    = vtx_in.payload.coord_z;

  assign k   = W1'(j) + W1'(span);
  assign mim = modn(mi, n);
  assign km  = modn(k, n);
  assign d1  = mi - W1'(j);
  assign d2  = k - mi;
  assign b1v = b1_zero ? '0 : b1_q;
  assign b2v = b2_zero ? '0 : b2_q;
  assign cand = sat_add(sum1, b2v);

  assign si    = W1'(spl_q);
  assign ci    = W1'(cur_i);
  assign end_m = modn(ci + W1'(cur_span), n);
  assign ls    = (si >= ci) ? si - ci : n - (ci - si);
  assign rs    = (end_m >= si) ? end_m - si : n - (si - end_m);
  assign last_tri = (sp == '0) && (rs < W1'(2)) && (ls < W1'(2));
  assign sp_m1 = STK_AW'(sp - SP_W'(1));

  assign areq.p = p_r;
  assign areq.q = q_r;
  assign areq.r = vq;

  assign tri_out.valid   = out_valid;
  assign tri_out.payload = out_item;

  always_comb begin
    state_next   = state;
    vtx_in.ready = 1'b0;
    areq.start   = 1'b0;
    vaddr        = j;
    bwr          = 1'b0;
    brd          = 1'b0;
    out_load     = 1'b0;
    stk_wr       = 1'b0;
    stk_rd       = 1'b0;
    stk_wdata    = {s_r, rs_r[IDX_W-1:0]};
    case (state)
      E_LOAD: begin
        vtx_in.ready = 1'b1;
        if (in_fire && vtx_in.payload.last_vertex && (n_load >= W1'(3))) state_next = E_RDV0;
      end
      E_RDV0: state_next = E_RDV1;
      E_RDV1: begin
        vaddr      = mim[IDX_W-1:0];
        state_next = E_RDV2;
      end
      E_RDV2: begin
        vaddr      = km[IDX_W-1:0];
        state_next = E_RDV3;
      end
      E_RDV3: begin
        areq.start = 1'b1;
        brd        = 1'b1;
        state_next = E_AREA;
      end
      E_AREA: begin
        if (arsp.done) state_next = E_ADD2;
      end
      E_ADD2: begin
        if (first) begin
          state_next = (span >= IDX_W'(3)) ? E_RDV0 : E_WRITE;
        end else begin
          state_next = (mi + W1'(3) <= k) ? E_RDV0 : E_WRITE;
        end
      end
      E_WRITE: begin
        bwr = 1'b1;
        if ((W1'(j) + W1'(1) >= n) && (W1'(span) + W1'(1) >= n)) begin
          state_next = E_SPL;
        end else begin
          state_next = E_RDV0;
        end
      end
      E_SPL: state_next = E_SPLW;
      E_SPLW: begin
        out_load = !out_valid || tri_out.ready;
        if (out_load) state_next = E_PUSHR;
      end
      E_PUSHR: begin
        stk_wr     = (rs_r >= W1'(2)) && (sp < SP_W'(STK_D));
        stk_wdata  = {s_r, rs_r[IDX_W-1:0]};
        state_next = E_PUSHL;
      end
      E_PUSHL: begin
        stk_wr     = (ls_r >= W1'(2)) && (sp < SP_W'(STK_D));
        stk_wdata  = {cur_i, ls_r[IDX_W-1:0]};
        state_next = E_POP;
      end
      E_POP: begin
        stk_rd     = (sp != '0);
        state_next = (sp == '0) ? E_LOAD : E_POPW;
      end
      E_POPW: begin
        state_next = (stk_q[IDX_W-1:0] < IDX_W'(2)) ? E_POP : E_SPL;
      end
      default: state_next = E_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwr) vstore[count[IDX_W-1:0]] <= vin;
    vq <= vstore[vaddr];
  end

  always_ff @(posedge clk) begin
    if (bwr) begin
      best_mem[{j, span}]  <= best_r;
      split_mem[{j, span}] <= pick;
    end
    if (brd) begin
      b1_q    <= best_mem[{j, d1[IDX_W-1:0]}];
      b2_q    <= best_mem[{mim[IDX_W-1:0], d2[IDX_W-1:0]}];
      b1_zero <= d1 < W1'(2);
      b2_zero <= d2 < W1'(2);
    end
    spl_q <= split_mem[{cur_i, cur_span}];
  end

  always_ff @(posedge clk) begin
    if (stk_wr) stack_mem[sp[STK_AW-1:0]] <= stk_wdata;
    if (stk_rd) stk_q <= stack_mem[sp_m1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_LOAD;
      count     <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (tri_out.valid && tri_out.ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) count <= vtx_in.payload.last_vertex ? '0 : n_load;
      if (stk_wr) sp <= sp + SP_W'(1);
      if (stk_rd) sp <= sp - SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      E_LOAD: begin
        if (in_fire && vtx_in.payload.last_vertex) begin
          n     <= n_load;
          span  <= IDX_W'(2);
          j     <= '0;
          mi    <= W1'(1);
          first <= 1'b1;
        end
      end
      E_RDV1: p_r <= vq;
      E_RDV2: q_r <= vq;
      E_AREA: begin
        if (arsp.done) sum1 <= sat_add(b1v, arsp.area);
      end
      E_ADD2: begin
        if (first || (cand < best_r)) begin
          best_r <= cand;
          pick   <= mim[IDX_W-1:0];
        end
        first <= 1'b0;
        mi    <= first ? W1'(j) + W1'(1) : mi + W1'(1);
      end
      E_WRITE: begin
        if ((j == '0) && (W1'(span) + W1'(1) == n)) total_r <= best_r;
        if (W1'(j) + W1'(1) < n) begin
          j     <= j + IDX_W'(1);
          mi    <= W1'(j) + W1'(span);
          first <= 1'b1;
        end else if (W1'(span) + W1'(1) < n) begin
          span  <= span + IDX_W'(1);
          j     <= '0;
          mi    <= W1'(span);
          first <= 1'b1;
        end else begin
          cur_i    <= '0;
          cur_span <= IDX_W'(n - W1'(1));
        end
      end
      E_SPLW: begin
        if (out_load) begin
          s_r                    <= spl_q;
          ls_r                   <= ls;
          rs_r                   <= rs;
          out_item.corner_a      <= to_corner(ci);
          out_item.corner_b      <= to_corner(end_m);
          out_item.corner_c      <= to_corner(si);
          out_item.total_area    <= last_tri ? total_r : '0;
          out_item.last_triangle <= last_tri;
        end
      end
      E_POPW: begin
        cur_i    <= stk_q[ENT_W-1:IDX_W];
        cur_span <= stk_q[IDX_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/min_area_polygon_triangulation.sv -----
// Sequence: a loop of n vertices is loaded vertex by vertex, then the interval
// table is filled (each candidate split costs one pass of the shared area
// unit: 6 cross products, 9 partial squares and a 39-step square root), then
// the triangles are emitted one by one.
// Throughput: one loop at a time; no vertex is taken while a run is under way.
// Reset: rst, synchronous; clears the vertex count, the stack and the output.
// ----------------------------------------------------------------------------
// min_area_polygon_triangulation
// Minimum total-area triangulation of a closed 3D loop, emitted as triples.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_area_polygon_triangulation #(
  parameter int MAX_VERTICES = mapt_pkg::MAX_VERTICES_DEF
) (
  input logic           clk,
  input logic           rst,
  mapt_stream_if.sink   vtx_in,
  mapt_stream_if.source tri_out
);
  import mapt_pkg::*;

  area_req_t areq;
  area_rsp_t arsp;

  mapt_engine #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .vtx_in (vtx_in),
    .tri_out(tri_out),
    .areq   (areq),
    .arsp   (arsp)
  );

  mapt_area_unit u_area (
    .clk(clk),
    .rst(rst),
    .req(areq),
    .rsp(arsp)
  );

  `ASSERT_SAME_CYCLE(a_no_accept_busy, clk, rst, areq.start, !vtx_in.ready)
  `ASSERT_NEXT_CYCLE(a_area_latency, clk, rst, areq.start, !arsp.done)
  `ASSERT_SAME_CYCLE(a_total_on_last, clk, rst, tri_out.valid && !tri_out.payload.last_triangle, tri_out.payload.total_area == '0)

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the minimum-area loop triangulation block. Loops of 3D
// vertices go in over the vertex channel; each loaded vertex also goes to a
// local interval-DP model, whose triangles are queued and compared field by
// field with each triangle transfer. Directed loops come first: short loops,
// coordinate extremes, a degenerate triangle, a tie, and a full vertex store.
// Random loops follow, mostly small, with idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import mapt_pkg::*;

  localparam int  NV        = 32;
  localparam int  RAND_ITEMS = 230;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam logic [AREA_W-1:0] AREA_TOP = {AREA_W{1'b1}};

  typedef struct {
    int x;
    int y;
    int z;
    bit last;
    int n_exp;
    int a;
    int b;
    int c;
    longint area;
  } dir_row_t;

  logic clk;
  logic rst;

  mapt_stream_if #(.T(vtx_item_t)) vtx_ch ();
  mapt_stream_if #(.T(tri_item_t)) tri_ch ();

  min_area_polygon_triangulation u_top (
    .clk     (clk),
    .rst     (rst),
    .vtx_in  (vtx_ch),
    .tri_out (tri_ch)
  );

  longint            vx [NV];
  longint            vy [NV];
  longint            vz [NV];
  int                loaded;
  logic [AREA_W-1:0] min_area [NV][NV];
  int                split_at [NV][NV];
  tri_item_t         tri_expect [$];
  int                errors = 0;
  longint            cycles = 0;
  int                sent;
  int                stall;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [AREA_W-1:0] clamp_sum(logic [AREA_W-1:0] p,
                                                   logic [AREA_W-1:0] q);
    logic [AREA_W:0] s;
    s = {1'b0, p} + {1'b0, q};
    return s[AREA_W] ? AREA_TOP : s[AREA_W-1:0];
  endfunction

  function automatic logic [AREA_W-1:0] face_area(int ia, int ib, int ic);
    longint       ax, ay, az, bx, by, bz, c0, c1, c2;
    logic [127:0] sq, t, root;
    ax = vx[ib] - vx[ia]; ay = vy[ib] - vy[ia]; az = vz[ib] - vz[ia];
    bx = vx[ic] - vx[ia]; by = vy[ic] - vy[ia]; bz = vz[ic] - vz[ia];
    c0 = ay * bz - az * by;
    c1 = az * bx - ax * bz;
    c2 = ax * by - ay * bx;
    if (c0 < 0) c0 = -c0;
    if (c1 < 0) c1 = -c1;
    if (c2 < 0) c2 = -c2;
    sq = 128'(c0) * 128'(c0) + 128'(c1) * 128'(c1) + 128'(c2) * 128'(c2);
    sq = sq << (2 * AREA_FRAC_BITS);
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      t = root | (128'd1 << k);
      if (t * t <= sq) root = t;
    end
    root = root >> 1;
    return (root > 128'(AREA_TOP)) ? AREA_TOP : root[AREA_W-1:0];
  endfunction

  task automatic solve_loop(int n);
    int                k, pick;
    logic [AREA_W-1:0] best, cand;
    for (int j = 0; j < n; j++) begin
      min_area[j][0] = '0;
      min_area[j][1] = '0;
      min_area[j][2] = face_area(j, (j + 1) % n, (j + 2) % n);
      split_at[j][2] = (j + 1) % n;
    end
    for (int span = 3; span < n; span++) begin
      for (int j = 0; j < n; j++) begin
        k = j + span;
        best = clamp_sum(min_area[j][span-1], face_area(j, (k - 1) % n, k % n));
        pick = (k - 1) % n;
        for (int m = j + 1; m < k; m++) begin
          cand = clamp_sum(min_area[j][m-j], face_area(j, m % n, k % n));
          cand = clamp_sum(cand, min_area[m % n][k-m]);
          if (cand < best) begin
            best = cand;
            pick = m % n;
          end
        end
        min_area[j][span] = best;
        split_at[j][span] = pick;
      end
    end
  endtask

  task automatic list_triangles(int n, ref tri_item_t tris[$]);
    int        st_i [NV+2];
    int        st_s [NV+2];
    int        sp, i, span, s, ls, rs;
    tri_item_t t;
    sp = 0;
    st_i[0] = 0; st_s[0] = n - 1; sp = 1;
    while (sp > 0) begin
      sp--;
      i = st_i[sp] % n;
      span = st_s[sp] % n;
      if (span >= 2) begin
        s = split_at[i][span] % n;
        t.corner_a = CORNER_W'(i);
        t.corner_b = CORNER_W'((i + span) % n);
        t.corner_c = CORNER_W'(s);
        t.total_area = '0;
        t.last_triangle = 1'b0;
        tris.push_back(t);
        ls = (s + n - i) % n;
        rs = (i + span + n - s) % n;
        if (rs >= 2 && sp < NV + 2) begin
          st_i[sp] = s; st_s[sp] = rs; sp++;
        end
        if (ls >= 2 && sp < NV + 2) begin
          st_i[sp] = i; st_s[sp] = ls; sp++;
        end
      end
    end
    if (tris.size() > 0) begin
      tris[tris.size()-1].total_area = min_area[0][n-1];
      tris[tris.size()-1].last_triangle = 1'b1;
    end
  endtask

  task automatic take_vertex(vtx_item_t it, ref tri_item_t tris[$]);
    int n;
    if (loaded < NV) begin
      vx[loaded] = longint'(it.coord_x);
      vy[loaded] = longint'(it.coord_y);
      vz[loaded] = longint'(it.coord_z);
      loaded++;
    end
    if (it.last_vertex) begin
      n = loaded;
      loaded = 0;
      if (n >= 3) begin
        solve_loop(n);
        list_triangles(n, tris);
      end
    end
  endtask

  task automatic push_vertex(vtx_item_t it, int n_exp, tri_item_t typed);
    tri_item_t tris [$];
    vtx_ch.valid   <= 1'b1;
    vtx_ch.payload <= it;
    do @(posedge clk); while (!vtx_ch.ready);
    take_vertex(it, tris);
    if (n_exp >= 0) begin
      tris.delete();
      if (n_exp > 0) tris.push_back(typed);
    end
    foreach (tris[k]) tri_expect.push_back(tris[k]);
    sent++;
    if ($urandom_range(0, 3) == 0) begin
      vtx_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  function automatic int pick_coord(int mode);
    int e;
    case (mode)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 16) - 8;
      default: begin
        e = $urandom_range(0, 3);
        return (e == 0) ? -32768 : (e == 1) ? 32767 : (e == 2) ? 0 : -1;
      end
    endcase
  endfunction

  task automatic push_loop(int n, int mode);
    vtx_item_t it;
    tri_item_t none;
    none = '0;
    for (int k = 0; k < n; k++) begin
      it.coord_x = COORD_W'(pick_coord(mode));
      it.coord_y = COORD_W'(pick_coord(mode));
      it.coord_z = COORD_W'(pick_coord(mode));
      it.last_vertex = (k == n - 1);
      push_vertex(it, -1, none);
    end
  endtask

  // output side: random stalls, mostly short
  always @(posedge clk) begin
    if (rst) begin
      tri_ch.ready <= 1'b0;
      stall <= 0;
    end else if (stall > 0) begin
      tri_ch.ready <= 1'b0;
      stall <= stall - 1;
    end else begin
      case ($urandom_range(0, 99))
        0, 1, 2, 3, 4, 5, 6, 7: stall <= $urandom_range(1, 3);
        8, 9: stall <= $urandom_range(10, 40);
        default: stall <= 0;
      endcase
      tri_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tri_item_t want;
    if (!rst && tri_ch.valid && tri_ch.ready) begin
      if (tri_expect.size() == 0) begin
        $display("%0t: unexpected triangle %p", $time, tri_ch.payload);
        errors++;
      end else begin
        want = tri_expect.pop_front();
        if (tri_ch.payload.corner_a !== want.corner_a) begin
          $display("%0t: corner_a exp %0d got %0d", $time, want.corner_a,
                   tri_ch.payload.corner_a);
          errors++;
        end
        if (tri_ch.payload.corner_b !== want.corner_b) begin
          $display("%0t: corner_b exp %0d got %0d", $time, want.corner_b,
                   tri_ch.payload.corner_b);
          errors++;
        end
        if (tri_ch.payload.corner_c !== want.corner_c) begin
          $display("%0t: corner_c exp %0d got %0d", $time, want.corner_c,
                   tri_ch.payload.corner_c);
          errors++;
        end
        if (tri_ch.payload.total_area !== want.total_area) begin
          $display("%0t: total_area exp %0d got %0d", $time, want.total_area,
                   tri_ch.payload.total_area);
          errors++;
        end
        if (tri_ch.payload.last_triangle !== want.last_triangle) begin
          $display("%0t: last_triangle exp %0d got %0d", $time, want.last_triangle,
                   tri_ch.payload.last_triangle);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dir_row_t  rows [18];
    vtx_item_t it;
    tri_item_t typed;
    int        r, n, mode;
    sent = 0;
    loaded = 0;
    rows = '{
      '{0, 0, 0, 1, 0, 0, 0, 0, 0},
      '{-32768, 32767, -32768, 0, 0, 0, 0, 0, 0},
      '{32767, -32768, 32767, 1, 0, 0, 0, 0, 0},
      '{5, 5, 5, 0, 0, 0, 0, 0, 0},
      '{5, 5, 5, 0, 0, 0, 0, 0, 0},
      '{5, 5, 5, 1, 1, 0, 2, 1, 0},
      '{-32768, -32768, -32768, 0, 0, 0, 0, 0, 0},
      '{32767, -32768, -32768, 0, 0, 0, 0, 0, 0},
      '{-32768, 32767, 32767, 1, -1, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{16, 0, 0, 0, 0, 0, 0, 0, 0},
      '{16, 16, 0, 0, 0, 0, 0, 0, 0},
      '{0, 16, 0, 1, -1, 0, 0, 0, 0},
      '{32767, 0, -1, 0, 0, 0, 0, 0, 0},
      '{0, 32767, 0, 0, 0, 0, 0, 0, 0},
      '{-32768, 0, 32767, 0, 0, 0, 0, 0, 0},
      '{0, -32768, -1, 0, 0, 0, 0, 0, 0},
      '{-1, -1, 0, 1, -1, 0, 0, 0, 0}
    };
    rst <= 1'b1;
    vtx_ch.valid <= 1'b0;
    vtx_ch.payload <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      it.coord_x = COORD_W'(rows[k].x);
      it.coord_y = COORD_W'(rows[k].y);
      it.coord_z = COORD_W'(rows[k].z);
      it.last_vertex = rows[k].last;
      typed.corner_a = CORNER_W'(rows[k].a);
      typed.corner_b = CORNER_W'(rows[k].b);
      typed.corner_c = CORNER_W'(rows[k].c);
      typed.total_area = AREA_W'(rows[k].area);
      typed.last_triangle = 1'b1;
      push_vertex(it, rows[k].n_exp, typed);
    end

    // full store: two extra vertices are dropped
    push_loop(NV + 2, 1);

    while (sent < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      n = (r < 5) ? $urandom_range(1, 2) :
          (r < 9) ? $urandom_range(10, 12) : $urandom_range(3, 8);
      mode = $urandom_range(0, 2);
      push_loop(n, mode);
    end
    vtx_ch.valid <= 1'b0;

    while (tri_expect.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
